// ----- hw/rtl/rifft_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package rifft_pkg;

  // Work values carry guard bits above the Q1.23 input range
  localparam int unsigned WORD_W   = 36;
  localparam int unsigned TW_W     = 18;
  localparam int unsigned PROD_W   = WORD_W + TW_W;
  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned TW_SHIFT = 16;

  localparam logic signed [TW_W-1:0] HALF_SQRT2 = 18'sd46341;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_CONJ,
    OP_CAPU,
    OP_CAPV,
    OP_MRC,
    OP_MIS,
    OP_MRS,
    OP_MIC,
    OP_WRV,
    OP_KCAP,
    OP_KEV,
    OP_KMUL,
    OP_KRND,
    OP_KOD,
    OP_KWR,
    OP_EMLD
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [2:0] idx;
    logic [4:0] tw;
    logic       last;
  } dp_cmd_t;

  typedef struct packed {
    logic signed [TW_W-1:0] cr;
    logic signed [TW_W-1:0] ci;
  } tw_t;

  // cos(2*pi*k/64) in Q2.16, k = 0..16
  function automatic logic signed [TW_W-1:0] quarter_cos(input logic [4:0] k);
    logic signed [TW_W-1:0] c;
    case (k)
      5'd0:    c = 18'sd65536;
      5'd1:    c = 18'sd65220;
      5'd2:    c = 18'sd64277;
      5'd3:    c = 18'sd62714;
      5'd4:    c = 18'sd60547;
      5'd5:    c = 18'sd57798;
      5'd6:    c = 18'sd54491;
      5'd7:    c = 18'sd50660;
      5'd8:    c = 18'sd46341;
      5'd9:    c = 18'sd41576;
      5'd10:   c = 18'sd36410;
      5'd11:   c = 18'sd30893;
      5'd12:   c = 18'sd25080;
      5'd13:   c = 18'sd19024;
      5'd14:   c = 18'sd12785;
      5'd15:   c = 18'sd6424;
      default: c = 18'sd0;
    endcase
    return c;
  endfunction

  // Forward twiddle exp(-2*pi*i*k/64) for k in 0..31
  function automatic tw_t twiddle(input logic [4:0] k);
    tw_t t;
    if (k <= 5'd16) begin
      t.cr = quarter_cos(k);
      t.ci = -quarter_cos(5'd16 - k);
    end else begin
      t.cr = -quarter_cos(5'd0 - k);
      t.ci = -quarter_cos(k - 5'd16);
    end
    return t;
  endfunction

  // Add half an LSB, floor shift by 16
  function automatic logic signed [WORD_W-1:0] round_tw(input logic signed [PROD_W:0] v);
    logic signed [PROD_W:0] s;
    s = v + (PROD_W+1)'(32768);
    return WORD_W'(s >>> TW_SHIFT);
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/rifft_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rifft_ram #(
  parameter int unsigned WIDTH = 72,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- hw/rtl/rifft_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rifft_dp #(
  parameter int unsigned POINTS = 64
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire rifft_pkg::dp_cmd_t        cmd_i,
  input  wire logic [$clog2(POINTS)-1:0] raddr_i,
  input  wire logic [$clog2(POINTS)-1:0] waddr_i,
  input  wire logic [47:0]               in_data_i,
  input  wire logic                      out_ready_i,
  output logic                           out_valid_o,
  output logic [23:0]                    out_data_o,
  output logic                           out_last_o,
  output logic                           out_fire_o
);

  localparam int unsigned LB = $clog2(POINTS);
  localparam int unsigned WW = rifft_pkg::WORD_W;
  localparam int unsigned PW = rifft_pkg::PROD_W;
  localparam int unsigned TW = rifft_pkg::TW_W;
  localparam int unsigned SW = rifft_pkg::SAMPLE_W;

  localparam logic signed [WW-1:0] SMAX = WW'(8388607);
  localparam logic signed [WW-1:0] SMIN = -WW'(8388608);

  logic              we;
  logic [2*WW-1:0]   wdata;
  logic [2*WW-1:0]   rdata;
  logic signed [WW-1:0] rd_re, rd_im;

  logic [23:0]          bin_re_q, bin_im_q;
  logic signed [WW-1:0] u_re_q, u_im_q, ar_q, ai_q, vr_q;
  logic signed [TW-1:0] cr_q, ci_q;
  logic signed [PW-1:0] p_q, acc_q;
  logic signed [WW-1:0] x_re_q [8];
  logic signed [WW-1:0] x_im_q [8];
  logic signed [WW-1:0] kop_q [4];
  logic signed [WW-1:0] t_q [4];
  logic signed [WW-1:0] y_q [8];
  logic [SW-1:0]        sample_q;
  logic                 last_q;
  logic                 ovalid_q, ovalid_d;

  logic signed [WW-1:0] mul_a;
  logic signed [TW-1:0] mul_b;
  rifft_pkg::tw_t       tw;

  logic signed [WW-1:0] e_t0r, e_t1r, e_t1i, e_t2r, e_t3r, e_t3i;
  logic signed [WW-1:0] e_s0, e_s1, e_s2, e_s3;
  logic signed [WW-1:0] e_ar1, e_ai1, e_ar3, e_ai3;
  logic signed [WW-1:0] o_t0r, o_t2r, o_s0, o_s1, o_s2, o_s3;
  logic signed [WW-1:0] shifted;
  logic signed [WW-1:0] satv;

  function automatic logic signed [WW-1:0] sx(input logic [23:0] v);
    return {{(WW-24){v[23]}}, v};
  endfunction

  assign rd_re = rdata[WW-1:0];
  assign rd_im = rdata[2*WW-1:WW];
  assign tw    = rifft_pkg::twiddle(cmd_i.tw);

  rifft_ram #(
    .WIDTH(2 * WW),
    .DEPTH(POINTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr_i),
    .wdata_i(wdata),
    .raddr_i(raddr_i),
    .rdata_o(rdata)
  );

  always_comb begin
    we    = 1'b0;
    wdata = '0;
    case (cmd_i.op)
      rifft_pkg::OP_LOAD: begin
        we    = 1'b1;
        wdata = {sx(in_data_i[47:24]), sx(in_data_i[23:0])};
      end
      rifft_pkg::OP_CONJ: begin
        we    = 1'b1;
        wdata = {-sx(bin_im_q), sx(bin_re_q)};
      end
      rifft_pkg::OP_CAPV: begin
        we    = 1'b1;
        wdata = {u_im_q + rd_im, u_re_q + rd_re};
      end
      rifft_pkg::OP_WRV: begin
        we    = 1'b1;
        wdata = {rifft_pkg::round_tw($signed({acc_q[PW-1], acc_q}) + $signed({p_q[PW-1], p_q})),
                 vr_q};
      end
      rifft_pkg::OP_KWR: begin
        we    = 1'b1;
        wdata = {{WW{1'b0}}, y_q[cmd_i.idx]};
      end
      default: begin
        we    = 1'b0;
      end
    endcase
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = ar_q;
    mul_b = cr_q;
    case (cmd_i.op)
      rifft_pkg::OP_MIS: begin
        mul_a = ai_q;
        mul_b = ci_q;
      end
      rifft_pkg::OP_MRS: begin
        mul_a = ar_q;
        mul_b = ci_q;
      end
      rifft_pkg::OP_MIC: begin
        mul_a = ai_q;
        mul_b = cr_q;
      end
      rifft_pkg::OP_KMUL: begin
        mul_a = kop_q[cmd_i.idx[1:0]];
        mul_b = rifft_pkg::HALF_SQRT2;
      end
      default: begin
        mul_a = ar_q;
        mul_b = cr_q;
      end
    endcase
  end

  // Kernel even half and multiplier operands
  assign e_t0r = x_re_q[0] + x_re_q[4];
  assign e_t1r = x_re_q[1] + x_re_q[5];
  assign e_t1i = x_im_q[1] + x_im_q[5];
  assign e_t2r = x_re_q[2] + x_re_q[6];
  assign e_t3r = x_re_q[3] + x_re_q[7];
  assign e_t3i = x_im_q[3] + x_im_q[7];
  assign e_s0  = e_t0r + e_t2r;
  assign e_s1  = e_t1r + e_t3r;
  assign e_s2  = e_t0r - e_t2r;
  assign e_s3  = e_t1i - e_t3i;
  assign e_ar1 = x_re_q[1] - x_re_q[5];
  assign e_ai1 = x_im_q[1] - x_im_q[5];
  assign e_ar3 = x_re_q[3] - x_re_q[7];
  assign e_ai3 = x_im_q[3] - x_im_q[7];

  // Kernel odd half
  assign o_t0r = x_re_q[0] - x_re_q[4];
  assign o_t2r = x_im_q[2] - x_im_q[6];
  assign o_s0  = o_t0r + o_t2r;
  assign o_s1  = t_q[0] + t_q[2];
  assign o_s2  = o_t0r - o_t2r;
  assign o_s3  = t_q[1] - t_q[3];

  // Divide by the frame length, then clamp to Q1.23
  assign shifted = rd_re >>> LB;
  always_comb begin
    if (shifted > SMAX) begin
      satv = SMAX;
    end else if (shifted < SMIN) begin
      satv = SMIN;
    end else begin
      satv = shifted;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      rifft_pkg::OP_LOAD: begin
        bin_re_q <= in_data_i[23:0];
        bin_im_q <= in_data_i[47:24];
      end
      rifft_pkg::OP_CAPU: begin
        u_re_q <= rd_re;
        u_im_q <= rd_im;
      end
      rifft_pkg::OP_CAPV: begin
        ar_q <= u_re_q - rd_re;
        ai_q <= u_im_q - rd_im;
        cr_q <= tw.cr;
        ci_q <= tw.ci;
      end
      rifft_pkg::OP_MRC: begin
        p_q <= mul_a * mul_b;
      end
      rifft_pkg::OP_MIS, rifft_pkg::OP_MIC: begin
        acc_q <= p_q;
        p_q   <= mul_a * mul_b;
      end
      rifft_pkg::OP_MRS: begin
        vr_q <= rifft_pkg::round_tw($signed({acc_q[PW-1], acc_q}) - $signed({p_q[PW-1], p_q}));
        p_q  <= mul_a * mul_b;
      end
      rifft_pkg::OP_KCAP: begin
        x_re_q[cmd_i.idx] <= rd_re;
        x_im_q[cmd_i.idx] <= rd_im;
      end
      rifft_pkg::OP_KEV: begin
        y_q[0]   <= e_s0 + e_s1;
        y_q[1]   <= e_s0 - e_s1;
        y_q[2]   <= e_s2 + e_s3;
        y_q[3]   <= e_s2 - e_s3;
        kop_q[0] <= e_ar1 + e_ai1;
        kop_q[1] <= e_ai1 - e_ar1;
        kop_q[2] <= e_ai3 - e_ar3;
        kop_q[3] <= -(e_ar3 + e_ai3);
      end
      rifft_pkg::OP_KMUL: begin
        p_q <= mul_a * mul_b;
      end
      rifft_pkg::OP_KRND: begin
        t_q[cmd_i.idx[1:0]] <= rifft_pkg::round_tw($signed({p_q[PW-1], p_q}));
      end
      rifft_pkg::OP_KOD: begin
        y_q[4] <= o_s0 + o_s1;
        y_q[5] <= o_s0 - o_s1;
        y_q[6] <= o_s2 + o_s3;
        y_q[7] <= o_s2 - o_s3;
      end
      rifft_pkg::OP_EMLD: begin
        sample_q <= satv[SW-1:0];
        last_q   <= cmd_i.last;
      end
      default: begin
        last_q <= last_q;
      end
    endcase
  end

  assign out_fire_o = ovalid_q & out_ready_i;

  always_comb begin
    ovalid_d = ovalid_q;
    if (out_fire_o) begin
      ovalid_d = 1'b0;
    end
    if (cmd_i.op == rifft_pkg::OP_EMLD) begin
      ovalid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else begin
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = sample_q;
  assign out_last_o  = last_q;

endmodule
`default_nettype wire

// ----- hw/rtl/rifft_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rifft_ctrl #(
  parameter int unsigned POINTS = 64
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic                      out_fire_i,
  output rifft_pkg::dp_cmd_t             cmd_o,
  output logic [$clog2(POINTS)-1:0]      raddr_o,
  output logic [$clog2(POINTS)-1:0]      waddr_o
);

  localparam int unsigned LB   = $clog2(POINTS);
  localparam int unsigned HALF = POINTS / 2;
  localparam int unsigned NST  = LB - 3;
  localparam int unsigned SW   = (NST > 1) ? $clog2(NST) : 1;
  localparam int unsigned BW   = LB - 3;

  typedef enum logic [20:0] {
    S_IDLE   = 21'h000001,
    S_CONJ   = 21'h000002,
    S_BF_RU  = 21'h000004,
    S_BF_RV  = 21'h000008,
    S_BF_SUB = 21'h000010,
    S_BF_M1  = 21'h000020,
    S_BF_M2  = 21'h000040,
    S_BF_M3  = 21'h000080,
    S_BF_M4  = 21'h000100,
    S_BF_WV  = 21'h000200,
    S_KN_RD  = 21'h000400,
    S_KN_RL  = 21'h000800,
    S_KN_EV  = 21'h001000,
    S_KN_MUL = 21'h002000,
    S_KN_RND = 21'h004000,
    S_KN_OD  = 21'h008000,
    S_KN_WR  = 21'h010000,
    S_EM_RD  = 21'h020000,
    S_EM_LD  = 21'h040000,
    S_EM_WT  = 21'h080000,
    S_SPARE  = 21'h100000
  } state_e;

  state_e          state_q, state_d;
  logic [LB-1:0]   cnt_q, cnt_d;
  logic [LB-1:0]   bins_q, bins_d;
  logic [SW-1:0]   stg_q, stg_d;
  logic [BW-1:0]   blk_q, blk_d;

  logic [2:0]      h;
  logic [LB-1:0]   j, lowmask, bf_u, bf_v;
  logic [5:0]      k6;
  logic [LB-1:0]   neg_n, src;

  // Butterfly addresses: insert a zero bit at the half-span position
  always_comb begin
    h       = 3'(LB - 1) - 3'(stg_q);
    j       = {1'b0, cnt_q[LB-2:0]};
    lowmask = (LB'(1) << h) - LB'(1);
    bf_u    = ((j & ~lowmask) << 1) | (j & lowmask);
    bf_v    = bf_u | (LB'(1) << h);
    k6      = 6'(j & lowmask) << (3'(6 - LB) + 3'(stg_q));
  end

  // Output order: reversed bit-reversed index
  always_comb begin
    neg_n = LB'(0) - cnt_q;
    for (int b = 0; b < LB; b++) begin
      src[b] = neg_n[LB-1-b];
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    bins_d     = bins_q;
    stg_d      = stg_q;
    blk_d      = blk_q;
    in_ready_o = 1'b0;
    cmd_o      = '{op: rifft_pkg::OP_NOP, idx: 3'd0, tw: 5'd0, last: 1'b0};
    raddr_o    = '0;
    waddr_o    = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        waddr_o    = bins_q;
        if (in_valid_i) begin
          cmd_o.op = rifft_pkg::OP_LOAD;
          if (bins_q == LB'(HALF)) begin
            bins_d  = '0;
            cnt_d   = '0;
            stg_d   = '0;
            state_d = S_BF_RU;
          end else if (bins_q == '0) begin
            bins_d = LB'(1);
          end else begin
            bins_d  = bins_q + LB'(1);
            state_d = S_CONJ;
          end
        end
      end
      S_CONJ: begin
        // mirror the bin just stored to POINTS - k
        cmd_o.op = rifft_pkg::OP_CONJ;
        waddr_o  = LB'(0) - (bins_q - LB'(1));
        state_d  = S_IDLE;
      end
      S_BF_RU: begin
        raddr_o = bf_u;
        state_d = S_BF_RV;
      end
      S_BF_RV: begin
        raddr_o  = bf_v;
        cmd_o.op = rifft_pkg::OP_CAPU;
        state_d  = S_BF_SUB;
      end
      S_BF_SUB: begin
        cmd_o.op = rifft_pkg::OP_CAPV;
        cmd_o.tw = k6[4:0];
        waddr_o  = bf_u;
        state_d  = S_BF_M1;
      end
      S_BF_M1: begin
        cmd_o.op = rifft_pkg::OP_MRC;
        state_d  = S_BF_M2;
      end
      S_BF_M2: begin
        cmd_o.op = rifft_pkg::OP_MIS;
        state_d  = S_BF_M3;
      end
      S_BF_M3: begin
        cmd_o.op = rifft_pkg::OP_MRS;
        state_d  = S_BF_M4;
      end
      S_BF_M4: begin
        cmd_o.op = rifft_pkg::OP_MIC;
        state_d  = S_BF_WV;
      end
      S_BF_WV: begin
        cmd_o.op = rifft_pkg::OP_WRV;
        waddr_o  = bf_v;
        if (cnt_q[LB-2:0] == (LB-1)'(HALF - 1)) begin
          cnt_d = '0;
          if (stg_q == SW'(NST - 1)) begin
            blk_d   = '0;
            state_d = S_KN_RD;
          end else begin
            stg_d   = stg_q + SW'(1);
            state_d = S_BF_RU;
          end
        end else begin
          cnt_d   = cnt_q + LB'(1);
          state_d = S_BF_RU;
        end
      end
      S_KN_RD: begin
        raddr_o   = {blk_q, cnt_q[2:0]};
        cmd_o.idx = cnt_q[2:0] - 3'd1;
        if (cnt_q[2:0] != 3'd0) begin
          cmd_o.op = rifft_pkg::OP_KCAP;
        end
        if (cnt_q[2:0] == 3'd7) begin
          cnt_d   = '0;
          state_d = S_KN_RL;
        end else begin
          cnt_d = cnt_q + LB'(1);
        end
      end
      S_KN_RL: begin
        cmd_o.op  = rifft_pkg::OP_KCAP;
        cmd_o.idx = 3'd7;
        state_d   = S_KN_EV;
      end
      S_KN_EV: begin
        cmd_o.op = rifft_pkg::OP_KEV;
        cnt_d    = '0;
        state_d  = S_KN_MUL;
      end
      S_KN_MUL: begin
        cmd_o.op  = rifft_pkg::OP_KMUL;
        cmd_o.idx = cnt_q[2:0];
        state_d   = S_KN_RND;
      end
      S_KN_RND: begin
        cmd_o.op  = rifft_pkg::OP_KRND;
        cmd_o.idx = cnt_q[2:0];
        if (cnt_q[1:0] == 2'd3) begin
          cnt_d   = '0;
          state_d = S_KN_OD;
        end else begin
          cnt_d   = cnt_q + LB'(1);
          state_d = S_KN_MUL;
        end
      end
      S_KN_OD: begin
        cmd_o.op = rifft_pkg::OP_KOD;
        state_d  = S_KN_WR;
      end
      S_KN_WR: begin
        cmd_o.op  = rifft_pkg::OP_KWR;
        cmd_o.idx = cnt_q[2:0];
        waddr_o   = {blk_q, cnt_q[2:0]};
        if (cnt_q[2:0] == 3'd7) begin
          cnt_d = '0;
          if (blk_q == '1) begin
            state_d = S_EM_RD;
          end else begin
            blk_d   = blk_q + BW'(1);
            state_d = S_KN_RD;
          end
        end else begin
          cnt_d = cnt_q + LB'(1);
        end
      end
      S_EM_RD: begin
        raddr_o = src;
        state_d = S_EM_LD;
      end
      S_EM_LD: begin
        cmd_o.op   = rifft_pkg::OP_EMLD;
        cmd_o.last = (cnt_q == LB'(POINTS - 1));
        state_d    = S_EM_WT;
      end
      S_EM_WT: begin
        // hold the word until the receiver takes it
        if (out_fire_i) begin
          if (cnt_q == LB'(POINTS - 1)) begin
            cnt_d   = '0;
            state_d = S_IDLE;
          end else begin
            cnt_d   = cnt_q + LB'(1);
            state_d = S_EM_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      bins_q  <= '0;
      stg_q   <= '0;
      blk_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      bins_q  <= bins_d;
      stg_q   <= stg_d;
      blk_q   <= blk_d;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/real_inverse_fft.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Complex-to-real inverse FFT of POINTS samples.
// Slave stream: one spectrum bin per word, bins 0..POINTS/2 in order;
//   tdata[23:0] real part, tdata[47:24] imaginary part, both Q1.23.
// Master stream: POINTS time samples per frame, Q1.23 saturated in
//   tdata[23:0]; tlast marks the final sample.
// Bins 1..POINTS/2-1 each add a conjugate step (the conjugate copy
//   is written to the mirrored slot of the single-port-write work RAM).
// On the last bin the frame runs from that RAM: (log2(POINTS)-3) stages
//   of POINTS/2 butterflies, sharing one multiplier, then POINTS/8
//   eight-point kernels, then the samples go out one at a time.
// No bin is taken while a frame is computed or emitted; one frame at a time.
// A stalled receiver holds the current sample and pauses the emit sequence.
// Reset clears the bin counter and the output valid; RAM contents are left
//   as they are and are rewritten by every frame before use.
module real_inverse_fft #(
  parameter int unsigned POINTS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // bin_real, bin_imag
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // sample
  output logic             m_axis_tlast   // sample_last
);

  rifft_pkg::dp_cmd_t          cmd;
  logic [$clog2(POINTS)-1:0]   raddr, waddr;
  logic                        out_fire;

  rifft_ctrl #(
    .POINTS(POINTS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .out_fire_i(out_fire),
    .cmd_o     (cmd),
    .raddr_o   (raddr),
    .waddr_o   (waddr)
  );

  rifft_dp #(
    .POINTS(POINTS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .raddr_i    (raddr),
    .waddr_i    (waddr),
    .in_data_i  (s_axis_tdata),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_data_o (m_axis_tdata),
    .out_last_o (m_axis_tlast),
    .out_fire_o (out_fire)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/rifft_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rifft_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);

  // never take a bin while a sample is on offer
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while output valid");

  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
    else $error("output continues after last sample");

  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
    else $error("output appears right after a bin");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled output word changed");

endmodule

bind real_inverse_fft rifft_chk u_rifft_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);
`default_nettype wire
